>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed: condition violated");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// Symbol subscription table package
// Shared key type, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sst_pkg;

  // 19-byte symbol, big-endian; packed order gives unsigned key order
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] mid;
    logic [23:0] lo;
  } key_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] REG_REUSE    = 1'd0;
  localparam logic [CFG_IW-1:0] REG_CAPACITY = 1'd1;

  localparam int SUBS_W = 5;
  localparam logic [SUBS_W-1:0] SUBS_MAX = 5'd31;

  function automatic logic key_less(input key_t a, input key_t b);
    return a < b;
  endfunction

endpackage

>>> sv/symbol_subscription_table_top.sv
// ----------------------------------------------------------------------------
// Symbol subscription table
// Key-sorted symbol table with per-room subscriber counts and client bitmaps.
// ----------------------------------------------------------------------------
// The table lives in a ring of ROOMS cells that rotates one place per cycle
// past a controller at its head while a table pass runs, and holds still otherwise.
// Search, delete and an insert rejected as full: one lookup pass. Insert of a
// known key: lookup pass, update pass. Insert of an appended key: lookup pass,
// sorted insertion pass. Insert that reclaims a room: lookup pass, compaction
// pass, sorted insertion pass. Reset all takes no pass. One item is in flight at
// a time; a finished result waits in the output register while the next beat is
// taken. After rst_n the client bitmap is cleared by a sweep over all rooms,
// during which in_ready stays low; configuration writes are taken at any time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module symbol_subscription_table_top import sst_pkg::*; #(
  parameter int ROOMS   = 256,
  parameter int CLIENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [63:0]       in_key_hi,
  input  logic [63:0]       in_key_mid,
  input  logic [23:0]       in_key_lo,
  input  logic              in_has_client,
  input  logic [3:0]        in_client_id,
  input  logic [31:0]       in_sub_mask,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_room,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int RW   = $clog2(ROOMS);
  localparam int NW   = $clog2(ROOMS + 1);
  localparam int CMPW = (NW > CFG_DW) ? NW : CFG_DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MWR  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_INS  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  // configuration
  logic              reuse_en_r;
  logic [CFG_DW-1:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_en_r <= 1'b0;
      capacity_r <= CFG_DW'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REUSE:    reuse_en_r <= cfg_wdata[0];
        REG_CAPACITY: capacity_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // controller state
  logic [3:0]         state_r, state_nxt;
  logic [1:0]         op_r;
  key_t               key_r;
  logic               has_r;
  logic [3:0]         cid_r;
  logic               mask_nz_r;
  logic [RW-1:0]      j_r, j_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               fnd_r, fnd_nxt;
  logic               flive_r, flive_nxt;
  logic [RW-1:0]      fpos_r, fpos_nxt;
  logic [RW-1:0]      froom_r, froom_nxt;
  logic               got_r, got_nxt;
  logic [RW-1:0]      rp_r, rp_nxt;
  logic [RW-1:0]      rroom_r, rroom_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [RW-1:0]      room_r, room_nxt;
  logic               reuse_r, reuse_nxt;
  logic               inc_r, inc_nxt;
  logic               ins_done_r, ins_done_nxt;
  key_t               cy_key_r, cy_key_nxt;
  logic [RW-1:0]      cy_room_r, cy_room_nxt;
  logic               cy_live_r, cy_live_nxt;
  logic [SUBS_W-1:0]  cy_subs_r, cy_subs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [7:0]         out_room_r, out_room_nxt;

  // ring and bitmap connections
  logic               shift;
  key_t               t_key, h_key, p_key;
  logic [RW-1:0]      t_room, h_room, p_room;
  logic               t_live, h_live, p_live;
  logic [SUBS_W-1:0]  t_subs, h_subs, p_subs;
  logic [CLIENTS-1:0] rd_data, wr_data;
  logic               wr_en, init_done;

  sst_chain #(.ROOMS(ROOMS)) u_chain (
    .clk    (clk),
    .shift  (shift),
    .t_key  (t_key),
    .t_room (t_room),
    .t_live (t_live),
    .t_subs (t_subs),
    .h_key  (h_key),
    .h_room (h_room),
    .h_live (h_live),
    .h_subs (h_subs),
    .p_key  (p_key),
    .p_room (p_room),
    .p_live (p_live),
    .p_subs (p_subs)
  );

  sst_submem #(.ROOMS(ROOMS), .CLIENTS(CLIENTS)) u_submem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (room_r),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (room_r),
    .wr_data   (wr_data),
    .init_done (init_done)
  );

  // derived terms
  logic [CMPW-1:0]    cap_w;
  logic               full;
  logic               client_ok;
  logic [CLIENTS-1:0] cl_hot;
  logic               sweep_end;
  logic               accept;

  assign cap_w     = (CMPW'(capacity_r) > CMPW'(ROOMS)) ? CMPW'(ROOMS) : CMPW'(capacity_r);
  assign full      = CMPW'(cnt_r) >= cap_w;
  assign client_ok = has_r && (32'(cid_r) < CLIENTS);
  assign cl_hot    = client_ok ? (CLIENTS'(1) << cid_r) : '0;
  assign sweep_end = (j_r == RW'(ROOMS - 1));
  assign in_ready  = (state_r == S_IDLE) && init_done;
  assign accept    = in_valid && in_ready;
  assign wr_data   = rd_data | (mask_nz_r ? cl_hot : '0);

  // per-cycle head work
  logic              match, cand, shifted, mark;
  logic [CMPW-1:0]   sidx;
  logic [NW-1:0]     n_ins;
  logic [SUBS_W-1:0] base_subs;
  key_t              s_key;
  logic [RW-1:0]     s_room;
  logic              s_live;
  logic [SUBS_W-1:0] s_subs;

  always_comb begin
    match     = (CMPW'(j_r) < CMPW'(cnt_r)) && (h_key == key_r) && !fnd_r;
    cand      = !got_r && (CMPW'(j_r) < cap_w) && (CMPW'(h_room) < cap_w) && (h_subs == '0);
    shifted   = (j_r >= rp_r);
    sidx      = CMPW'(j_r) + CMPW'(shifted);
    s_key     = shifted ? p_key  : h_key;
    s_room    = shifted ? p_room : h_room;
    s_live    = shifted ? p_live : h_live;
    s_subs    = shifted ? p_subs : h_subs;
    mark      = (sidx < cap_w) && (CMPW'(s_room) < cap_w) && (s_subs == '0);
    n_ins     = reuse_r ? (cnt_r - 1'b1) : cnt_r;
    base_subs = flive_r ? h_subs : '0;
  end

  // controller
  always_comb begin
    state_nxt      = state_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    fnd_nxt        = fnd_r;
    flive_nxt      = flive_r;
    fpos_nxt       = fpos_r;
    froom_nxt      = froom_r;
    got_nxt        = got_r;
    rp_nxt         = rp_r;
    rroom_nxt      = rroom_r;
    st_nxt         = st_r;
    room_nxt       = room_r;
    reuse_nxt      = reuse_r;
    inc_nxt        = inc_r;
    ins_done_nxt   = ins_done_r;
    cy_key_nxt     = cy_key_r;
    cy_room_nxt    = cy_room_r;
    cy_live_nxt    = cy_live_r;
    cy_subs_nxt    = cy_subs_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_room_nxt   = out_room_r;
    shift          = 1'b0;
    t_key          = h_key;
    t_room         = h_room;
    t_live         = h_live;
    t_subs         = h_subs;
    wr_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          fnd_nxt   = 1'b0;
          got_nxt   = 1'b0;
          j_nxt     = '0;
          state_nxt = (in_operation == OP_CLEAR) ? S_DEC : S_LOOK;
        end
      end

      // lookup pass; delete clears the live mark as the entry goes by
      S_LOOK: begin
        shift = 1'b1;
        if (match) begin
          fnd_nxt   = 1'b1;
          flive_nxt = h_live;
          fpos_nxt  = j_r;
          froom_nxt = h_room;
          if (op_r == OP_DELETE) begin
            t_live = 1'b0;
          end
        end
        if (cand) begin
          got_nxt   = 1'b1;
          rp_nxt    = j_r;
          rroom_nxt = h_room;
        end
        j_nxt = j_r + 1'b1;
        if (sweep_end) begin
          j_nxt     = '0;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        st_nxt    = ST_OK;
        reuse_nxt = 1'b0;
        state_nxt = S_FIN;
        case (op_r)
          OP_CLEAR: begin
            cnt_nxt  = '0;
            room_nxt = '0;
          end
          OP_INSERT: begin
            if (fnd_r) begin
              room_nxt  = froom_r;
              state_nxt = S_MRD;
            end else if (!full) begin
              room_nxt  = RW'(cnt_r);
              state_nxt = S_MRD;
            end else if (reuse_en_r && got_r) begin
              room_nxt  = rroom_r;
              reuse_nxt = 1'b1;
              state_nxt = S_MRD;
            end else begin
              st_nxt = ST_FULL;
            end
          end
          default: begin
            room_nxt = froom_r;
            st_nxt   = (fnd_r && flive_r) ? ST_OK : ST_MISS;
          end
        endcase
      end

      S_MRD: state_nxt = S_MWR;

      // subscribe: new client to the room counts, mask bit recorded
      S_MWR: begin
        wr_en        = 1'b1;
        inc_nxt      = client_ok && ((rd_data & cl_hot) == '0);
        ins_done_nxt = 1'b0;
        j_nxt        = '0;
        state_nxt    = fnd_r ? S_UPD : (reuse_r ? S_CMP : S_INS);
      end

      // revive / count update of a known key
      S_UPD: begin
        shift = 1'b1;
        if (j_r == fpos_r) begin
          t_live = 1'b1;
          t_subs = (inc_r && base_subs != SUBS_MAX) ? base_subs + 1'b1 : base_subs;
        end
        j_nxt = j_r + 1'b1;
        if (sweep_end) begin
          j_nxt     = '0;
          state_nxt = S_FIN;
        end
      end

      // drop the reclaimed entry and mark idle rooms dead
      S_CMP: begin
        shift  = 1'b1;
        t_key  = s_key;
        t_room = s_room;
        t_live = s_live && !mark;
        t_subs = s_subs;
        j_nxt  = j_r + 1'b1;
        if (sweep_end) begin
          j_nxt     = '0;
          state_nxt = S_INS;
        end
      end

      // sorted insertion, entries behind the new one move up a place
      S_INS: begin
        shift = 1'b1;
        if (ins_done_r) begin
          t_key  = cy_key_r;
          t_room = cy_room_r;
          t_live = cy_live_r;
          t_subs = cy_subs_r;
        end else if ((CMPW'(j_r) < CMPW'(n_ins)) && key_less(h_key, key_r)) begin
          t_key = h_key;
        end else begin
          t_key        = key_r;
          t_room       = room_r;
          t_live       = 1'b1;
          t_subs       = SUBS_W'(inc_r);
          ins_done_nxt = 1'b1;
        end
        cy_key_nxt  = h_key;
        cy_room_nxt = h_room;
        cy_live_nxt = h_live;
        cy_subs_nxt = h_subs;
        j_nxt       = j_r + 1'b1;
        if (sweep_end) begin
          j_nxt     = '0;
          cnt_nxt   = reuse_r ? cnt_r : cnt_r + 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_room_nxt   = (st_r == ST_OK) ? 8'(room_r) : 8'd0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      key_r     <= '{hi: in_key_hi, mid: in_key_mid, lo: in_key_lo};
      has_r     <= in_has_client;
      cid_r     <= in_client_id;
      mask_nz_r <= (in_sub_mask != '0);
    end
    fnd_r        <= fnd_nxt;
    flive_r      <= flive_nxt;
    fpos_r       <= fpos_nxt;
    froom_r      <= froom_nxt;
    got_r        <= got_nxt;
    rp_r         <= rp_nxt;
    rroom_r      <= rroom_nxt;
    st_r         <= st_nxt;
    room_r       <= room_nxt;
    reuse_r      <= reuse_nxt;
    inc_r        <= inc_nxt;
    ins_done_r   <= ins_done_nxt;
    cy_key_r     <= cy_key_nxt;
    cy_room_r    <= cy_room_nxt;
    cy_live_r    <= cy_live_nxt;
    cy_subs_r    <= cy_subs_nxt;
    out_status_r <= out_status_nxt;
    out_room_r   <= out_room_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_room   = out_room_r;

  // checks
  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, CMPW'(cnt_r) <= CMPW'(ROOMS))
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid, out_status <= ST_FULL)
  `ASSERT_IMPLY(a_ready_after_init, clk, rst_n, in_ready, init_done)
  `ASSERT_IMPLY(a_miss_no_room, clk, rst_n, out_valid && out_status != ST_OK, out_room == 8'd0)

endmodule

>>> sv/sst_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one table entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; #(
  parameter int RW = 8
) (
  input  logic              clk,
  input  logic              shift,
  input  key_t              d_key,
  input  logic [RW-1:0]     d_room,
  input  logic              d_live,
  input  logic [SUBS_W-1:0] d_subs,
  output key_t              q_key,
  output logic [RW-1:0]     q_room,
  output logic              q_live,
  output logic [SUBS_W-1:0] q_subs
);

  key_t              key_r;
  logic [RW-1:0]     room_r;
  logic              live_r;
  logic [SUBS_W-1:0] subs_r;

  // entry storage, payload only
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r  <= d_key;
      room_r <= d_room;
      live_r <= d_live;
      subs_r <= d_subs;
    end
  end

  assign q_key  = key_r;
  assign q_room = room_r;
  assign q_live = live_r;
  assign q_subs = subs_r;

endmodule

>>> sv/sst_chain.sv
// ----------------------------------------------------------------------------
// Cell ring
// ROOMS cells in a row; each shift moves every entry one place to the head,
// the tail takes the entry written back by the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_chain import sst_pkg::*; #(
  parameter  int ROOMS = 256,
  localparam int RW    = $clog2(ROOMS)
) (
  input  logic              clk,
  input  logic              shift,
  input  key_t              t_key,
  input  logic [RW-1:0]     t_room,
  input  logic              t_live,
  input  logic [SUBS_W-1:0] t_subs,
  output key_t              h_key,
  output logic [RW-1:0]     h_room,
  output logic              h_live,
  output logic [SUBS_W-1:0] h_subs,
  output key_t              p_key,
  output logic [RW-1:0]     p_room,
  output logic              p_live,
  output logic [SUBS_W-1:0] p_subs
);

  key_t              c_key  [ROOMS];
  logic [RW-1:0]     c_room [ROOMS];
  logic              c_live [ROOMS];
  logic [SUBS_W-1:0] c_subs [ROOMS];

  for (genvar k = 0; k < ROOMS; k++) begin : g_cell
    key_t              d_key;
    logic [RW-1:0]     d_room;
    logic              d_live;
    logic [SUBS_W-1:0] d_subs;

    // last cell is fed from the write-back path, the others from their neighbor
    if (k == ROOMS - 1) begin : g_tail
      assign d_key  = t_key;
      assign d_room = t_room;
      assign d_live = t_live;
      assign d_subs = t_subs;
    end else begin : g_link
      assign d_key  = c_key[k+1];
      assign d_room = c_room[k+1];
      assign d_live = c_live[k+1];
      assign d_subs = c_subs[k+1];
    end

    sst_cell #(.RW(RW)) u_cell (
      .clk    (clk),
      .shift  (shift),
      .d_key  (d_key),
      .d_room (d_room),
      .d_live (d_live),
      .d_subs (d_subs),
      .q_key  (c_key[k]),
      .q_room (c_room[k]),
      .q_live (c_live[k]),
      .q_subs (c_subs[k])
    );
  end

  // head and the entry right behind it
  assign h_key  = c_key[0];
  assign h_room = c_room[0];
  assign h_live = c_live[0];
  assign h_subs = c_subs[0];
  assign p_key  = c_key[1];
  assign p_room = c_room[1];
  assign p_live = c_live[1];
  assign p_subs = c_subs[1];

endmodule

>>> sv/sst_submem.sv
// ----------------------------------------------------------------------------
// Client subscription bitmap
// One row per room, one bit per client: set once the client's room mask is
// nonzero. Cleared by a sweep over every row after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_submem #(
  parameter  int ROOMS   = 256,
  parameter  int CLIENTS = 16,
  localparam int RW      = $clog2(ROOMS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RW-1:0]      rd_addr,
  output logic [CLIENTS-1:0] rd_data,
  input  logic               wr_en,
  input  logic [RW-1:0]      wr_addr,
  input  logic [CLIENTS-1:0] wr_data,
  output logic               init_done
);

  logic [CLIENTS-1:0] mem [ROOMS];
  logic [CLIENTS-1:0] rd_data_r;
  logic               clearing_r;
  logic [RW-1:0]      clr_r;

  // clearing pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == RW'(ROOMS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data   = rd_data_r;
  assign init_done = !clearing_r;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol subscription table testbench
// Drives insert, delete, search and clear beats through valid/ready, keeps a
// cycle-free model of the sorted table, room counters and client masks, and
// checks every result beat in order. Runs a directed table first, then
// random phases over several reuse/capacity settings with random idling.
// ----------------------------------------------------------------------------

module tb_top;
  import sst_pkg::*;

  localparam int NROOM     = 256;
  localparam int NCLIENT   = 16;
  localparam int RAND_PER  = 120;
  localparam int LIMIT     = 8000000;
  localparam int SETTLE    = 3 * NROOM + 40;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] room;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    key_t        key;
    logic        has;
    logic [3:0]  cid;
    logic [31:0] mask;
    logic        typed;
    result_t     res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_SEARCH;
  logic [63:0] in_key_hi = '0;
  logic [63:0] in_key_mid = '0;
  logic [23:0] in_key_lo = '0;
  logic in_has_client = 1'b0;
  logic [3:0] in_client_id = '0;
  logic [31:0] in_sub_mask = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_room;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = REG_REUSE;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  symbol_subscription_table_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table model
  key_t        tbl_key   [NROOM];
  logic [7:0]  tbl_room  [NROOM];
  logic        tbl_live  [NROOM];
  int          tbl_used;
  logic [4:0]  room_subs [NROOM];
  logic        room_ok   [NROOM];
  logic [31:0] cli_mask  [NCLIENT][NROOM];
  logic        reuse_en;
  logic [8:0]  cap_reg;

  result_t     pending_q[$];
  int          fails = 0;
  int          n_beats = 0;
  int          n_results = 0;
  int          n_full = 0;
  int          n_miss = 0;
  int          cycles = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  key_t        key_pool[$];
  dir_row_t    dir_tab[$];

  function automatic int lookup(input key_t k);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void add_sub(input logic has, input logic [3:0] cid,
                                  input logic [7:0] rm, input logic [31:0] mask);
    if (!has || cid >= NCLIENT) return;
    if (cli_mask[cid][rm] == '0) begin
      cli_mask[cid][rm] = mask;
      if (room_subs[rm] != SUBS_MAX) room_subs[rm]++;
    end else begin
      cli_mask[cid][rm] |= mask;
    end
  endfunction

  // Expected result of one accepted beat; updates the model state
  function automatic result_t table_apply(input logic [1:0] op, input key_t k,
                                          input logic has, input logic [3:0] cid,
                                          input logic [31:0] mask);
    result_t r;
    int f, pos, rm, cap;
    bit got;
    key_t tk;
    logic [7:0] tr;
    logic tl;
    r = '{status: ST_OK, room: 8'd0};
    f = lookup(k);
    cap = (cap_reg > NROOM) ? NROOM : cap_reg;
    case (op)
      OP_INSERT: begin
        if (f >= 0) begin
          rm = tbl_room[f];
          if (!tbl_live[f]) begin
            room_subs[rm] = '0;
            room_ok[rm] = 1'b1;
            tbl_live[f] = 1'b1;
          end
          add_sub(has, cid, 8'(rm), mask);
          r.room = 8'(rm);
          return r;
        end
        if (tbl_used >= cap) begin
          got = 0;
          pos = 0;
          rm = 0;
          if (!reuse_en) begin
            r.status = ST_FULL;
            return r;
          end
          // mark every idle room below capacity dead, take the first in key order
          for (int i = 0; i < cap; i++) begin
            if (tbl_room[i] >= cap) continue;
            if (room_subs[tbl_room[i]] == '0) begin
              room_ok[tbl_room[i]] = 1'b0;
              tbl_live[i] = 1'b0;
              if (!got) begin
                got = 1;
                pos = i;
                rm = tbl_room[i];
              end
            end
          end
          if (!got) begin
            r.status = ST_FULL;
            return r;
          end
        end else begin
          pos = tbl_used;
          rm = tbl_used;
        end
        tbl_key[pos] = k;
        tbl_room[pos] = 8'(rm);
        tbl_live[pos] = 1'b1;
        if (pos >= tbl_used) tbl_used = pos + 1;
        // move the new entry into key order
        while (pos > 0 && tbl_key[pos-1] > tbl_key[pos]) begin
          tk = tbl_key[pos-1]; tbl_key[pos-1] = tbl_key[pos]; tbl_key[pos] = tk;
          tr = tbl_room[pos-1]; tbl_room[pos-1] = tbl_room[pos]; tbl_room[pos] = tr;
          tl = tbl_live[pos-1]; tbl_live[pos-1] = tbl_live[pos]; tbl_live[pos] = tl;
          pos--;
        end
        while (pos + 1 < tbl_used && tbl_key[pos+1] < tbl_key[pos]) begin
          tk = tbl_key[pos+1]; tbl_key[pos+1] = tbl_key[pos]; tbl_key[pos] = tk;
          tr = tbl_room[pos+1]; tbl_room[pos+1] = tbl_room[pos]; tbl_room[pos] = tr;
          tl = tbl_live[pos+1]; tbl_live[pos+1] = tbl_live[pos]; tbl_live[pos] = tl;
          pos++;
        end
        room_subs[rm] = '0;
        room_ok[rm] = 1'b1;
        add_sub(has, cid, 8'(rm), mask);
        r.room = 8'(rm);
      end
      OP_DELETE, OP_SEARCH: begin
        if (f >= 0 && tbl_live[f]) begin
          r.room = tbl_room[f];
          if (op == OP_DELETE) begin
            tbl_live[f] = 1'b0;
            room_ok[tbl_room[f]] = 1'b0;
          end
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        for (int i = 0; i < NROOM; i++) begin
          room_subs[i] = '0;
          room_ok[i] = 1'b0;
        end
        tbl_used = 0;
      end
    endcase
    return r;
  endfunction

  // Present one beat and hold it until accepted
  task automatic send_beat(input logic [1:0] op, input key_t k, input logic has,
                           input logic [3:0] cid, input logic [31:0] mask,
                           input bit typed, input result_t typed_res);
    result_t r;
    in_valid <= 1'b1;
    in_operation <= op;
    {in_key_hi, in_key_mid, in_key_lo} <= k;
    in_has_client <= has;
    in_client_id <= cid;
    in_sub_mask <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = table_apply(op, k, has, cid, mask);
    pending_q.push_back(typed ? typed_res : r);
    n_beats++;
    // random gap after the beat
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REUSE) reuse_en = val[0];
    else cap_reg = val;
    @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] op, input key_t k, input logic has,
                         input logic [3:0] cid, input logic [31:0] mask,
                         input bit typed, input logic [1:0] st, input logic [7:0] rm);
    dir_row_t d;
    d.op = op; d.key = k; d.has = has; d.cid = cid; d.mask = mask;
    d.typed = typed; d.res = '{status: st, room: rm};
    dir_tab.push_back(d);
  endtask

  function automatic key_t rand_key;
    key_t k;
    k.hi = {$urandom, $urandom};
    k.mid = {$urandom, $urandom};
    k.lo = 24'($urandom);
    return k;
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d room %0d",
               out_status, out_room);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (out_status != e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          fails++;
        end
        if (out_room != e.room) begin
          $error("room: expected %0d, got %0d", e.room, out_room);
          fails++;
        end
        if (e.status == ST_FULL) n_full++;
        if (e.status == ST_MISS) n_miss++;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 2500) begin
          @(posedge clk);
          hold++;
        end
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    key_t kmax, kzero, ka, kb, kc;
    logic [1:0] op;
    logic [31:0] mask;
    int pick;
    int phase_reuse[10];
    int phase_cap[10];
    phase_reuse = '{0, 1, 0, 1, 1, 0, 1, 1, 1, 1};
    phase_cap   = '{256, 4, 3, 1, 0, 0, 300, 8, 256, 16};
    reuse_en = 1'b0;
    cap_reg = 9'd256;
    tbl_used = 0;
    for (int i = 0; i < NROOM; i++) begin
      room_subs[i] = '0;
      room_ok[i] = 1'b0;
      tbl_live[i] = 1'b0;
      for (int c = 0; c < NCLIENT; c++) cli_mask[c][i] = '0;
    end

    kmax = '1;
    kzero = '0;
    ka = '{hi: 64'h4142_0000_4300_0000, mid: 64'h0, lo: 24'h0};
    kb = '{hi: 64'h4142_0000_4300_0000, mid: 64'h0, lo: 24'h1};
    kc = '{hi: 64'h0, mid: 64'h0, lo: 24'hFFFFFF};
    key_pool = '{kmax, kzero, ka, kb, kc};
    while (key_pool.size() < 24) key_pool.push_back(rand_key());

    // directed rows: empty table, extremes, revive, counting, clear
    add_row(OP_SEARCH, kmax, 0, 0, 0, 1, ST_MISS, 0);
    add_row(OP_DELETE, kzero, 0, 0, 0, 1, ST_MISS, 0);
    add_row(OP_INSERT, kmax, 1, 4'hF, 32'hFFFF_FFFF, 1, ST_OK, 0);
    add_row(OP_INSERT, kzero, 1, 0, 32'h0, 1, ST_OK, 1);
    add_row(OP_INSERT, ka, 0, 0, 32'h1, 1, ST_OK, 2);
    add_row(OP_INSERT, kb, 1, 3, 32'h8000_0000, 1, ST_OK, 3);
    add_row(OP_INSERT, kc, 1, 7, 32'h5555_5555, 0, 0, 0);
    add_row(OP_SEARCH, kmax, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_SEARCH, kb, 0, 0, 0, 0, 0, 0);
    add_row(OP_DELETE, kzero, 0, 0, 0, 1, ST_OK, 1);
    add_row(OP_SEARCH, kzero, 0, 0, 0, 1, ST_MISS, 0);
    add_row(OP_DELETE, kzero, 0, 0, 0, 1, ST_MISS, 0);
    add_row(OP_INSERT, kzero, 1, 0, 32'h0, 1, ST_OK, 1);
    for (int i = 0; i < 6; i++) add_row(OP_INSERT, kzero, 1, 0, 32'h0, 0, 0, 0);
    add_row(OP_INSERT, kzero, 1, 9, 32'hAAAA_AAAA, 0, 0, 0);
    add_row(OP_INSERT, kmax, 0, 2, 32'h0, 0, 0, 0);
    add_row(OP_CLEAR, kmax, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_SEARCH, kmax, 0, 0, 0, 1, ST_MISS, 0);
    add_row(OP_INSERT, kb, 1, 3, 32'h2, 1, ST_OK, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].op, dir_tab[i].key, dir_tab[i].has, dir_tab[i].cid,
                dir_tab[i].mask, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // random phases over reuse and capacity settings
    for (int p = 0; p < 10; p++) begin
      repeat (SETTLE) @(posedge clk);
      write_reg(REG_REUSE, CFG_DW'(phase_reuse[p]));
      write_reg(REG_CAPACITY, CFG_DW'(phase_cap[p]));
      if (p == 1) hold_req = 1;
      if (p == 9) quiet = 1;
      for (int n = 0; n < RAND_PER; n++) begin
        pick = $urandom_range(0, 99);
        op = pick < 50 ? OP_INSERT : pick < 66 ? OP_DELETE : pick < 98 ? OP_SEARCH
                                                                        : OP_CLEAR;
        mask = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
        send_beat(op,
                  ($urandom_range(0, 6) == 0) ? rand_key()
                    : key_pool[$urandom_range(0, key_pool.size() - 1)],
                  $urandom_range(0, 4) != 0, 4'($urandom), mask, 0, '0);
      end
      // sender pauses here until the block has answered everything
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      fails++;
    end
    $display("Covered %0d beats, %0d results (%0d misses, %0d full) over 10 settings",
             n_beats, n_results, n_miss, n_full);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sst_chain.sv
sv/sst_submem.sv
sv/symbol_subscription_table_top.sv
tb/sv/tb_top.sv
